@@ hdl/hammersley_point_generator_unit_assert.svh @@
// assertion macros for the hammersley point generator checker
// no dependencies; expects clk and rst in the scope of use
`ifndef HAMMERSLEY_POINT_GENERATOR_UNIT_ASSERT_SVH
`define HAMMERSLEY_POINT_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define HPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/hpg_pkg.sv @@
// shared types, widths and prime tables of the hammersley point generator
// no dependencies
`timescale 1ns / 1ps
package hpg_pkg;

  localparam int INDEX_W  = 32;
  localparam int FRAC_W   = 32;
  localparam int COORD_W  = FRAC_W + 1;
  localparam int DIM_W    = 5;
  localparam int MAX_DIMS = 29;
  localparam int PRIME_W  = 7;
  localparam int MAGIC_W  = 33;
  localparam int WIDE_W   = 40;
  localparam int PROD_W   = INDEX_W + MAGIC_W;
  localparam int CNT_W    = $clog2(FRAC_W);

  localparam logic [63:0] TWO33 = 64'd8589934592;

  localparam logic [PRIME_W-1:0] PRIMES [MAX_DIMS] = '{
    7'd2,  7'd3,  7'd5,  7'd7,  7'd11, 7'd13, 7'd17, 7'd19, 7'd23, 7'd29,
    7'd31, 7'd37, 7'd41, 7'd43, 7'd47, 7'd53, 7'd59, 7'd61, 7'd67, 7'd71,
    7'd73, 7'd79, 7'd83, 7'd89, 7'd97, 7'd101, 7'd103, 7'd107, 7'd109};

  // floor(2^33 / p): quotient estimate is exact or one low
  localparam logic [MAGIC_W-1:0] MAGICS [MAX_DIMS] = '{
    33'(TWO33 / 64'd2),   33'(TWO33 / 64'd3),   33'(TWO33 / 64'd5),
    33'(TWO33 / 64'd7),   33'(TWO33 / 64'd11),  33'(TWO33 / 64'd13),
    33'(TWO33 / 64'd17),  33'(TWO33 / 64'd19),  33'(TWO33 / 64'd23),
    33'(TWO33 / 64'd29),  33'(TWO33 / 64'd31),  33'(TWO33 / 64'd37),
    33'(TWO33 / 64'd41),  33'(TWO33 / 64'd43),  33'(TWO33 / 64'd47),
    33'(TWO33 / 64'd53),  33'(TWO33 / 64'd59),  33'(TWO33 / 64'd61),
    33'(TWO33 / 64'd67),  33'(TWO33 / 64'd71),  33'(TWO33 / 64'd73),
    33'(TWO33 / 64'd79),  33'(TWO33 / 64'd83),  33'(TWO33 / 64'd89),
    33'(TWO33 / 64'd97),  33'(TWO33 / 64'd101), 33'(TWO33 / 64'd103),
    33'(TWO33 / 64'd107), 33'(TWO33 / 64'd109)};

  typedef struct packed {
    logic             load;
    logic             init;
    logic             mul;
    logic             est;
    logic             upd;
    logic             div_set;
    logic             div_step;
    logic [DIM_W-1:0] dim;
  } hpg_cmd_t;

  typedef struct packed {
    logic q_zero;
    logic sat;
  } hpg_stat_t;

endpackage

@@ hdl/hammersley_point_generator_unit.sv @@
// top level of the hammersley point generator: apb registers, controller, datapath
// depends on hpg_pkg, hpg_ctrl, hpg_datapath
`timescale 1ns / 1ps
//  channel   | handshake                         | payload
//  ----------+-----------------------------------+----------------------------------
//  command   | start, busy (taken: start & !busy)| point_index
//  result    | result_valid, one-cycle strobe    | dim_number, coordinate, last_coord
//  config    | apb write, pready tied high       | sample_count @0, dimension_count @4
//
// dimension 0 emits 1.0 when saturated, else runs a 32-step restoring divide
// dimension d loops check, multiply, estimate, update per base-p digit of the index, then divides
// a point's dimensions run one after another; base 2, with up to 32 digits, has the longest loop
// rst clears the controller and the registers (sample_count 1, dimension_count 2)
// results cannot be stalled: each one is on the ports for exactly one cycle
module hammersley_point_generator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [hpg_pkg::INDEX_W-1:0] point_index,
  output logic                        result_valid,
  output logic [hpg_pkg::DIM_W-1:0]   dim_number,
  output logic [hpg_pkg::COORD_W-1:0] coordinate,
  output logic                        last_coord,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import hpg_pkg::*;

  logic [31:0]      sample_count;
  logic [DIM_W-1:0] dimension_count;
  logic             wr;
  hpg_cmd_t         cmd;
  hpg_stat_t        stat;

  // register file: index is paddr[2]
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count    <= 32'd1;
      dimension_count <= DIM_W'(2);
    end else if (wr) begin
      if (paddr[2]) begin
        dimension_count <= pwdata[DIM_W-1:0];
      end else begin
        sample_count <= pwdata;
      end
    end
  end

  assign prdata = paddr[2] ? {{(32 - DIM_W){1'b0}}, dimension_count} : sample_count;

  hpg_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .dimension_count (dimension_count),
    .stat            (stat),
    .cmd             (cmd),
    .busy            (busy),
    .result_valid    (result_valid),
    .last_coord      (last_coord),
    .dim_number      (dim_number)
  );

  hpg_datapath u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .point_index  (point_index),
    .sample_count (sample_count),
    .stat         (stat),
    .coordinate   (coordinate)
  );

endmodule

@@ hdl/hpg_ctrl.sv @@
// controller state machine of the hammersley point generator
// depends on hpg_pkg
`timescale 1ns / 1ps
module hpg_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [hpg_pkg::DIM_W-1:0] dimension_count,
  input  hpg_pkg::hpg_stat_t       stat,
  output hpg_pkg::hpg_cmd_t        cmd,
  output logic                     busy,
  output logic                     result_valid,
  output logic                     last_coord,
  output logic [hpg_pkg::DIM_W-1:0] dim_number
);
  import hpg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_CHECK, S_MUL, S_EST, S_UPD, S_DIVSET, S_DIV
  } state_t;

  state_t           state;
  logic [DIM_W-1:0] dim;
  logic [DIM_W-1:0] count;
  logic [CNT_W-1:0] cnt;
  logic             emit;
  logic [DIM_W-1:0] eff_count;
  logic             is_last;
  logic             take;

  always_comb begin
    if (dimension_count == '0) begin
      eff_count = DIM_W'(1);
    end else if (dimension_count > DIM_W'(MAX_DIMS)) begin
      eff_count = DIM_W'(MAX_DIMS);
    end else begin
      eff_count = dimension_count;
    end
  end

  assign is_last = (dim == count - DIM_W'(1));

  // a new transaction only when the previous point is fully out
  assign take = start && !busy;

  always_comb begin
    cmd          = '0;
    cmd.dim      = dim;
    cmd.load     = (state == S_IDLE) && take;
    cmd.init     = (state == S_INIT);
    cmd.mul      = (state == S_MUL);
    cmd.est      = (state == S_EST);
    cmd.upd      = (state == S_UPD);
    cmd.div_set  = (state == S_DIVSET);
    cmd.div_step = (state == S_DIV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dim   <= '0;
      count <= '0;
      cnt   <= '0;
      emit  <= 1'b0;
    end else begin
      emit <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (take) begin
            dim   <= '0;
            count <= eff_count;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          cnt <= '0;
          if (dim == '0) begin
            if (stat.sat) begin
              emit  <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_DIV;
            end
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: state <= stat.q_zero ? S_DIVSET : S_MUL;
        S_MUL:   state <= S_EST;
        S_EST:   state <= S_UPD;
        S_UPD:   state <= S_CHECK;
        S_DIVSET: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(FRAC_W - 1)) begin
            emit  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // emit cycle: hold off in idle-looking slot, then move on
      if (emit) begin
        if (!is_last) begin
          dim   <= dim + DIM_W'(1);
          state <= S_INIT;
        end
      end
    end
  end

  assign busy         = (state != S_IDLE) || (emit && !is_last);
  assign result_valid = emit;
  assign last_coord   = emit && is_last;
  assign dim_number   = dim;

endmodule

@@ hdl/hpg_datapath.sv @@
// datapath: base-p digit extraction and shared restoring fraction divider
// depends on hpg_pkg
`timescale 1ns / 1ps
module hpg_datapath (
  input  logic                        clk,
  input  hpg_pkg::hpg_cmd_t           cmd,
  input  logic [hpg_pkg::INDEX_W-1:0] point_index,
  input  logic [31:0]                 sample_count,
  output hpg_pkg::hpg_stat_t          stat,
  output logic [hpg_pkg::COORD_W-1:0] coordinate
);
  import hpg_pkg::*;

  logic [INDEX_W-1:0] idx, q, est, estp;
  logic [WIDE_W-1:0]  mir, scale, rem, den;
  logic [PROD_W-1:0]  prod;
  logic [COORD_W-1:0] res;
  logic [DIM_W-1:0]   sel;
  logic [PRIME_W-1:0] p;
  logic [MAGIC_W-1:0] magic;
  logic [INDEX_W-1:0] r, dig, quo;
  logic               fix;
  logic [WIDE_W:0]    rem2;
  logic               ge;

  assign sel   = cmd.dim - DIM_W'(1);
  assign p     = PRIMES[sel];
  assign magic = MAGICS[sel];

  // correction of the one-low quotient estimate
  assign r   = q - estp;
  assign fix = (r >= INDEX_W'(p));
  assign dig = fix ? r - INDEX_W'(p) : r;
  assign quo = est + INDEX_W'(fix);

  assign rem2 = {rem, 1'b0};
  assign ge   = (rem2 >= {1'b0, den});

  assign stat.q_zero = (q == '0);
  assign stat.sat    = (sample_count == '0) || (idx >= sample_count);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx <= point_index;
    end
    if (cmd.init) begin
      if (cmd.dim == '0) begin
        rem <= WIDE_W'(idx);
        den <= WIDE_W'(sample_count);
        res <= stat.sat ? (COORD_W'(1) << FRAC_W) : '0;
      end else begin
        q     <= idx;
        mir   <= '0;
        scale <= WIDE_W'(1);
      end
    end
    if (cmd.mul) begin
      prod <= PROD_W'(q) * PROD_W'(magic);
    end
    if (cmd.est) begin
      est  <= prod[PROD_W-1:MAGIC_W];
      estp <= INDEX_W'(prod[PROD_W-1:MAGIC_W] * INDEX_W'(p));
    end
    if (cmd.upd) begin
      q     <= quo;
      mir   <= mir * WIDE_W'(p) + WIDE_W'(dig);
      scale <= scale * WIDE_W'(p);
    end
    if (cmd.div_set) begin
      rem <= mir;
      den <= scale;
      res <= '0;
    end
    if (cmd.div_step) begin
      rem <= ge ? WIDE_W'(rem2 - {1'b0, den}) : rem2[WIDE_W-1:0];
      res <= {res[COORD_W-2:0], ge};
    end
  end

  assign coordinate = res;

endmodule

@@ hdl/hpg_checker.sv @@
// port-level checker of the hammersley point generator, bound to the top level
// depends on hammersley_point_generator_unit_assert.svh
`timescale 1ns / 1ps
`include "hammersley_point_generator_unit_assert.svh"
module hpg_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid,
  input logic last_coord
);
  `HPG_ASSERT_NOW(a_last_strobed, last_coord, result_valid, "last_coord without strobe")
  `HPG_ASSERT_NOW(a_mid_busy, result_valid && !last_coord, busy, "idle before last coordinate")
  `HPG_ASSERT_NEXT(a_gap, result_valid && !last_coord, !result_valid, "coordinates back to back")
  `HPG_ASSERT_NEXT(a_take, start && !busy, busy || result_valid, "transaction not taken")
endmodule

bind hammersley_point_generator_unit hpg_checker u_hpg_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .last_coord   (last_coord)
);
